// ===== rtl/lgs_pkg.sv =====
// Shared types, constants and cell functions for the Life generation stream.
// No dependencies; every rtl module imports this package.
`default_nettype none

package lgs_pkg;

    localparam int MAX_COLS = 62;
    localparam int COL_W    = 6;
    localparam int ROW_W    = 12;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 24;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Register indexes (paddr[2])
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    typedef logic [MAX_COLS-1:0] row_t;

    // One queue transaction: up to two ready-made results plus an optional
    // last-row flush carrying the two rows it needs.
    typedef struct packed {
        logic             has_a;
        logic             has_b;
        logic             has_flush;
        logic             nxt_a;
        logic             chg_a;
        logic             nxt_b;
        logic             chg_b;
        logic [ROW_W-1:0] row_ab;
        logic [COL_W-1:0] col_a;
        logic [COL_W-1:0] col_b;
        logic [ROW_W-1:0] flush_row;
        row_t             above;
        row_t             here;
    } q_entry_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } front_stat_t;

    typedef struct packed {
        logic busy;
    } back_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_A,
        BK_B,
        BK_FLUSH
    } bk_state_t;

    // B3/S23
    function automatic logic life_next(input logic [7:0] nb, input logic cur);
        logic [3:0] cnt;
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt = cnt + {3'b000, nb[i]};
        end
        return (cnt == 4'd3) || (cur && (cnt == 4'd2));
    endfunction

    // Shift right by one within the first n bits; bit n-1 takes fill.
    function automatic row_t row_step(input row_t v, input logic [COL_W-1:0] n,
                                      input logic fill);
        row_t             r;
        row_t             sh;
        logic [COL_W-1:0] top;
        sh  = {1'b0, v[MAX_COLS-1:1]};
        top = n - 1'b1;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            if (COL_W'(i) == top)
                r[i] = fill;
            else if (COL_W'(i) < top)
                r[i] = sh[i];
            else
                r[i] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [COL_W-1:0] used_cols(input logic [COL_W-1:0] g);
        if (g == '0)
            return COL_W'(1);
        else if (g > COL_W'(MAX_COLS))
            return COL_W'(MAX_COLS);
        else
            return g;
    endfunction

    function automatic logic [ROW_W-1:0] used_rows(input logic [ROW_W-1:0] g);
        return (g == '0) ? ROW_W'(1) : g;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/life_generation_stream.sv =====
// Top level of the Life (B3/S23) generation stream: APB registers, front end,
// transaction queue and back end. Depends on lgs_pkg, lgs_front, lgs_queue, lgs_back.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s_*      | in  | s_tvalid / s_tready    | tdata[0] alive
//  m_*      | out | m_tvalid / m_tready    | tdata next_alive, changed, row, col;
//           |     |                        | tlast run_last; tuser generation_end
//  apb      | in  | psel & penable, pready | 0x0 grid_rows[11:0], 0x4 grid_cols[5:0]
//
// One cell is taken per cycle while the four-entry transaction queue has room.
// Results leave at one per cycle from the back end while m_tready is high; a generation's
// last cell adds one flush result per column in use, which the back end walks one column
// per cycle (again while m_tready is high) as the front keeps taking cells of the next generation.
// Reset (or any register write) clears the row stores and both counters.
// A stalled m_tready holds the output register and, once the queue fills, s_tready.
`default_nettype none

module life_generation_stream (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // cell stream in
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [lgs_pkg::IN_W-1:0]     s_tdata,   // [0] alive, [7:1] zero
    // result stream out
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    // [0] next_alive, [1] changed, [13:2] cell_row, [19:14] cell_col, [23:20] zero
    output      logic [lgs_pkg::OUT_W-1:0]    m_tdata,
    output      logic                         m_tlast,   // run_last
    output      logic                         m_tuser,   // [0] generation_end
    // register port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lgs_pkg::APB_AW-1:0]   paddr,
    input  wire logic [lgs_pkg::APB_DW-1:0]   pwdata,
    output      logic [lgs_pkg::APB_DW-1:0]   prdata,
    output      logic                         pready
);
    import lgs_pkg::*;

    logic [ROW_W-1:0] grid_rows_reg;
    logic [COL_W-1:0] grid_cols_reg;
    logic             cfg_wr;
    logic             reg_idx;
    logic [COL_W-1:0] ncols;
    logic [ROW_W-1:0] nrows;

    logic        q_full, q_push, q_pop, q_valid;
    q_entry_t    q_in, q_head;
    front_stat_t front_stat;
    back_stat_t  back_stat;

    // --- register port; register index is the word address bit
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_GRID_ROWS: prdata = {{(APB_DW-ROW_W){1'b0}}, grid_rows_reg};
            REG_GRID_COLS: prdata = {{(APB_DW-COL_W){1'b0}}, grid_cols_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= ROW_W'(64);
            grid_cols_reg <= COL_W'(32);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_GRID_ROWS: grid_rows_reg <= pwdata[ROW_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= pwdata[COL_W-1:0];
                default:       grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    // zero acts as one, column count saturates at MAX_COLS
    assign ncols = used_cols(grid_cols_reg);
    assign nrows = used_rows(grid_rows_reg);

    // --- front: window and row stores
    lgs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (cfg_wr),
        .ncols    (ncols),
        .nrows    (nrows),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in),
        .stat     (front_stat)
    );

    // --- transaction queue
    lgs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head),
        .valid (q_valid)
    );

    // --- back: result sequencer and output register
    lgs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ncols    (ncols),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .stat     (back_stat)
    );

    // --- checks
    // the generation's final result always closes its transaction
    a_gen_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("generation_end without run_last");

    // an idle back end picks up a waiting transaction on the next edge
    a_back_picks_up: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !back_stat.busy) |=> back_stat.busy)
        else $error("back end left a queued transaction waiting");

    // a register write restarts the generation at the first cell
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (front_stat.row == '0 && front_stat.col == '0))
        else $error("register write did not restart the generation");

endmodule

`default_nettype wire

// ===== rtl/lgs_front.sv =====
// Front end: accepts cells, keeps the three row stores and the 3x3 window,
// and queues result transactions. Depends on lgs_pkg.
`default_nettype none

module lgs_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        clr,
    input  wire logic [lgs_pkg::COL_W-1:0]   ncols,
    input  wire logic [lgs_pkg::ROW_W-1:0]   nrows,
    input  wire logic                        s_tvalid,
    output      logic                        s_tready,
    input  wire logic [lgs_pkg::IN_W-1:0]    s_tdata,
    input  wire logic                        q_full,
    output      logic                        q_push,
    output      lgs_pkg::q_entry_t           q_entry,
    output      lgs_pkg::front_stat_t        stat
);
    import lgs_pkg::*;

    // Rows rotate so the current column always sits at bit 0.
    row_t             upper_reg, upper_next;
    row_t             middle_reg, middle_next;
    row_t             incoming_reg, incoming_next;
    logic             up_h1_reg, up_h2_reg, mid_h1_reg, mid_h2_reg;
    logic             low_h1_reg, low_h2_reg;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic acc, alive, last_col, last_row, restart;
    row_t up_rot, mid_rot, inc_ins;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;
    assign alive    = s_tdata[0];
    assign last_col = (col_reg == ncols - 1'b1);
    assign last_row = (row_reg == nrows - 1'b1);
    assign restart  = clr || (acc && last_col && last_row);

    assign up_rot  = row_step(upper_reg, ncols, upper_reg[0]);
    assign mid_rot = row_step(middle_reg, ncols, middle_reg[0]);
    assign inc_ins = row_step(incoming_reg, ncols, alive);

    always_comb
    begin
        q_entry.has_a     = (row_reg != '0) && (col_reg != '0);
        q_entry.has_b     = (row_reg != '0) && last_col;
        q_entry.has_flush = last_col && last_row;
        // cell (r-1, c-1)
        q_entry.nxt_a     = life_next({up_h2_reg, up_h1_reg, upper_reg[0],
                                       mid_h2_reg, middle_reg[0],
                                       low_h2_reg, low_h1_reg, alive}, mid_h1_reg);
        q_entry.chg_a     = q_entry.nxt_a ^ mid_h1_reg;
        // cell (r-1, c) at the right edge; column c+1 is outside
        q_entry.nxt_b     = life_next({1'b0, up_h1_reg, upper_reg[0],
                                       1'b0, mid_h1_reg,
                                       1'b0, low_h1_reg, alive}, middle_reg[0]);
        q_entry.chg_b     = q_entry.nxt_b ^ middle_reg[0];
        q_entry.row_ab    = row_reg - 1'b1;
        q_entry.col_a     = col_reg - 1'b1;
        q_entry.col_b     = col_reg;
        q_entry.flush_row = row_reg;
        q_entry.above     = mid_rot;
        q_entry.here      = inc_ins;
    end

    assign q_push = acc && (q_entry.has_a || q_entry.has_b || q_entry.has_flush);

    always_comb
    begin
        upper_next    = upper_reg;
        middle_next   = middle_reg;
        incoming_next = incoming_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        if (restart)
        begin
            upper_next    = '0;
            middle_next   = '0;
            incoming_next = '0;
            row_next      = '0;
            col_next      = '0;
        end
        else if (acc && last_col)
        begin
            upper_next    = mid_rot;
            middle_next   = inc_ins;
            incoming_next = '0;
            row_next      = row_reg + 1'b1;
            col_next      = '0;
        end
        else if (acc)
        begin
            upper_next    = up_rot;
            middle_next   = mid_rot;
            incoming_next = inc_ins;
            col_next      = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg    <= '0;
            middle_reg   <= '0;
            incoming_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            up_h1_reg    <= 1'b0;
            up_h2_reg    <= 1'b0;
            mid_h1_reg   <= 1'b0;
            mid_h2_reg   <= 1'b0;
            low_h1_reg   <= 1'b0;
            low_h2_reg   <= 1'b0;
        end
        else
        begin
            upper_reg    <= upper_next;
            middle_reg   <= middle_next;
            incoming_reg <= incoming_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            if (restart || (acc && last_col))
            begin
                up_h1_reg  <= 1'b0;
                up_h2_reg  <= 1'b0;
                mid_h1_reg <= 1'b0;
                mid_h2_reg <= 1'b0;
                low_h1_reg <= 1'b0;
                low_h2_reg <= 1'b0;
            end
            else if (acc)
            begin
                up_h1_reg  <= upper_reg[0];
                up_h2_reg  <= up_h1_reg;
                mid_h1_reg <= middle_reg[0];
                mid_h2_reg <= mid_h1_reg;
                low_h1_reg <= alive;
                low_h2_reg <= low_h1_reg;
            end
        end
    end

    assign stat.row = row_reg;
    assign stat.col = col_reg;

endmodule

`default_nettype wire

// ===== rtl/lgs_queue.sv =====
// Short FIFO of result transactions between front and back.
// Depends on lgs_pkg.
`default_nettype none

module lgs_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lgs_pkg::q_entry_t din,
    output      logic              full,
    input  wire logic              pop,
    output      lgs_pkg::q_entry_t head,
    output      logic              valid
);
    import lgs_pkg::*;

    q_entry_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= din;
    end

endmodule

`default_nettype wire

// ===== rtl/lgs_back.sv =====
// Back end: plays out queued transactions one result per cycle while m_tready allows,
// walks the last-row flush, and holds the output register. Depends on lgs_pkg.
`default_nettype none

module lgs_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [lgs_pkg::COL_W-1:0]  ncols,
    input  wire logic                       q_valid,
    input  wire lgs_pkg::q_entry_t          q_head,
    output      logic                       q_pop,
    output      logic                       m_tvalid,
    input  wire logic                       m_tready,
    output      logic [lgs_pkg::OUT_W-1:0]  m_tdata,
    output      logic                       m_tlast,
    output      logic                       m_tuser,
    output      lgs_pkg::back_stat_t        stat
);
    import lgs_pkg::*;

    bk_state_t        state_reg, state_next, first_state;
    q_entry_t         job_reg;
    row_t             abv_reg, here_reg;
    logic             ah1_reg, hh1_reg;
    logic [COL_W-1:0] cc_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_last_reg, out_gen_end_reg;

    logic             emit, last_step, gen_end, res_nxt, res_chg;
    logic [ROW_W-1:0] res_row;
    logic [COL_W-1:0] res_col;

    assign emit  = (state_reg != BK_IDLE) && (!out_valid_reg || m_tready);
    assign q_pop = q_valid && ((state_reg == BK_IDLE) || (emit && last_step));

    always_comb
    begin
        if (q_head.has_a)
            first_state = BK_A;
        else if (q_head.has_b)
            first_state = BK_B;
        else
            first_state = BK_FLUSH;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                    state_next = first_state;
            end
            BK_A, BK_B, BK_FLUSH:
            begin
                if (emit && last_step)
                    state_next = q_valid ? first_state : BK_IDLE;
                else if (emit && state_reg == BK_A)
                    state_next = job_reg.has_b ? BK_B : BK_FLUSH;
                else if (emit && state_reg == BK_B)
                    state_next = BK_FLUSH;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // result of the current step
    always_comb
    begin
        res_nxt   = 1'b0;
        res_chg   = 1'b0;
        res_row   = job_reg.row_ab;
        res_col   = job_reg.col_a;
        last_step = 1'b0;
        gen_end   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                last_step = 1'b0;
            end
            BK_A:
            begin
                res_nxt   = job_reg.nxt_a;
                res_chg   = job_reg.chg_a;
                last_step = !job_reg.has_b && !job_reg.has_flush;
            end
            BK_B:
            begin
                res_nxt   = job_reg.nxt_b;
                res_chg   = job_reg.chg_b;
                res_col   = job_reg.col_b;
                last_step = !job_reg.has_flush;
            end
            BK_FLUSH:
            begin
                // row below is outside the grid
                res_nxt   = life_next({3'b000, ah1_reg, abv_reg[0], abv_reg[1],
                                       hh1_reg, here_reg[1]}, here_reg[0]);
                res_chg   = res_nxt ^ here_reg[0];
                res_row   = job_reg.flush_row;
                res_col   = cc_reg;
                last_step = (cc_reg == ncols - 1'b1);
                gen_end   = last_step;
            end
            default: last_step = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg  <= q_head;
            abv_reg  <= q_head.above;
            here_reg <= q_head.here;
            ah1_reg  <= 1'b0;
            hh1_reg  <= 1'b0;
            cc_reg   <= '0;
        end
        else if (emit && state_reg == BK_FLUSH)
        begin
            abv_reg  <= {1'b0, abv_reg[MAX_COLS-1:1]};
            here_reg <= {1'b0, here_reg[MAX_COLS-1:1]};
            ah1_reg  <= abv_reg[0];
            hh1_reg  <= here_reg[0];
            cc_reg   <= cc_reg + 1'b1;
        end
        if (emit)
        begin
            out_data_reg    <= {4'b0000, res_col, res_row, res_chg, res_nxt};
            out_last_reg    <= last_step;
            out_gen_end_reg <= gen_end;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_gen_end_reg;
    assign stat.busy = (state_reg != BK_IDLE);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for life_generation_stream: random and directed cell streams,
// next-generation prediction in SystemVerilog, field-by-field result checks.
// Depends on lgs_pkg and the life_generation_stream RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lgs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int BACKLOG_HOLD   = 300;

    // Register byte addresses: index times four.
    localparam logic [APB_AW-1:0] ADDR_GRID_ROWS = {REG_GRID_ROWS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_GRID_COLS = {REG_GRID_COLS, 2'b00};

    // One reported cell as it leaves the block.
    typedef struct packed {
        logic             next_alive;
        logic             changed;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic             run_last;
        logic             generation_end;
    } cell_report_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;     // [0] alive, [7:1] zero
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;     // [0] next_alive, [1] changed, [13:2] row, [19:14] col
    logic              m_tlast;     // run_last
    logic              m_tuser;     // [0] generation_end
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    life_generation_stream DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Cells waiting to go out, and cell reports predicted but not yet seen.
    logic         cells_to_send[$];
    cell_report_t expected_cells[$];

    // Shadow of the block: register values, three row stores, raster position.
    logic [ROW_W-1:0] grid_rows_reg;
    logic [COL_W-1:0] grid_cols_reg;
    row_t             rows_two_up;
    row_t             rows_one_up;
    row_t             rows_arriving;
    int               raster_row;
    int               raster_col;

    int mismatch_count;
    int cells_queued;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Life prediction
    // ------------------------------------------------------------------
    function automatic void clear_rows();
        rows_two_up   = '0;
        rows_one_up   = '0;
        rows_arriving = '0;
        raster_row    = 0;
        raster_col    = 0;
    endfunction

    // Cells past either edge of the grid are dead.
    function automatic int cell_state(row_t r, int c, int ncols);
        if (c < 0 || c >= ncols)
            return 0;
        return int'(r[c]);
    endfunction

    function automatic cell_report_t evolve_cell(row_t above, row_t here, row_t below,
                                                 int r, int c, int ncols);
        cell_report_t rep;
        int           neighbours;
        int           cur;
        neighbours = 0;
        cur        = cell_state(here, c, ncols);
        for (int dc = -1; dc <= 1; dc++)
        begin
            neighbours += cell_state(above, c + dc, ncols) + cell_state(below, c + dc, ncols);
            if (dc != 0)
                neighbours += cell_state(here, c + dc, ncols);
        end
        // B3/S23
        rep.next_alive     = (neighbours == 3) || (cur == 1 && neighbours == 2);
        rep.changed        = rep.next_alive ^ cur[0];
        rep.cell_row       = ROW_W'(r);
        rep.cell_col       = COL_W'(c);
        rep.run_last       = 1'b0;
        rep.generation_end = 1'b0;
        return rep;
    endfunction

    // Take one accepted cell and queue every report it releases.
    function automatic void take_cell(logic alive);
        cell_report_t batch[$];
        int           ncols;
        int           nrows;
        int           r;
        int           c;
        ncols = (grid_cols_reg == 0) ? 1 :
                (int'(grid_cols_reg) > MAX_COLS) ? MAX_COLS : int'(grid_cols_reg);
        nrows = (grid_rows_reg == 0) ? 1 : int'(grid_rows_reg);
        if (raster_col >= ncols || raster_row >= nrows)
            clear_rows();
        r = raster_row;
        c = raster_col;
        rows_arriving[c] = alive;

        // Cell up and to the left is complete; at the right edge, the one above too.
        if (r >= 1)
        begin
            if (c >= 1)
                batch.push_back(evolve_cell(rows_two_up, rows_one_up, rows_arriving,
                                            r - 1, c - 1, ncols));
            if (c == ncols - 1)
                batch.push_back(evolve_cell(rows_two_up, rows_one_up, rows_arriving,
                                            r - 1, c, ncols));
        end

        if (c == ncols - 1)
        begin
            if (r == nrows - 1)
            begin
                // Last cell of the generation: flush the bottom row against dead cells.
                for (int cc = 0; cc < ncols; cc++)
                    batch.push_back(evolve_cell(rows_one_up, rows_arriving, '0, r, cc, ncols));
                batch[batch.size() - 1].generation_end = 1'b1;
                clear_rows();
            end
            else
            begin
                rows_two_up   = rows_one_up;
                rows_one_up   = rows_arriving;
                rows_arriving = '0;
                raster_row    = r + 1;
                raster_col    = 0;
            end
        end
        else
        begin
            raster_col = c + 1;
        end

        if (batch.size() > 0)
            batch[batch.size() - 1].run_last = 1'b1;
        foreach (batch[i])
            expected_cells.push_back(batch[i]);
    endfunction

    // ------------------------------------------------------------------
    // Cell driver: one transaction per queued cell, random gaps between them
    // ------------------------------------------------------------------
    int send_gap;
    bit send_fast;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                take_cell(s_tdata[0]);
            if (s_tvalid && !s_tready)
            begin
                // held: keep offering the same cell
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (cells_to_send.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_W'(cells_to_send.pop_front());
                // Alternate bursts with no gaps and stretches of random gaps.
                if ($urandom_range(0, 31) == 0)
                    send_fast = !send_fast;
                send_gap = send_fast ? 0 : $urandom_range(0, 15);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each transaction, stalls m_tready at random
    // ------------------------------------------------------------------
    int  stall_left;
    int  hold_left;
    bit  recv_fast;
    bit  backlog_done;

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        cell_report_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_cells.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual tdata %h last %b user %b",
                             $realtime, m_tdata, m_tlast, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    check_field("next_alive", int'(want.next_alive), int'(m_tdata[0]));
                    check_field("changed", int'(want.changed), int'(m_tdata[1]));
                    check_field("cell_row", int'(want.cell_row), int'(m_tdata[13:2]));
                    check_field("cell_col", int'(want.cell_col), int'(m_tdata[19:14]));
                    check_field("run_last", int'(want.run_last), int'(m_tlast));
                    check_field("generation_end", int'(want.generation_end), int'(m_tuser));
                end
                // Once, while plenty of cells are still queued, stop reading for a
                // long time so the block's queue fills and s_tready drops.
                if (!backlog_done && cells_to_send.size() > 40)
                begin
                    backlog_done = 1'b1;
                    hold_left    = BACKLOG_HOLD;
                end
                if ($urandom_range(0, 31) == 0)
                    recv_fast = !recv_fast;
                stall_left = recv_fast ? 0 : $urandom_range(0, 15);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction on any port
    // ------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $realtime, expected_cells.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // APB write: setup then access; the register and the shadow both clear the
    // generation in progress.
    task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_GRID_ROWS)
            grid_rows_reg = value[ROW_W-1:0];
        else
            grid_cols_reg = value[COL_W-1:0];
        clear_rows();
        @(negedge clk);
    endtask

    // Wait for the block to go quiet: nothing left to send or to receive, then a
    // settling wait of SETTLE_CYCLES for cells that release no result.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cells_to_send.size() != 0 || s_tvalid || expected_cells.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_cell(logic alive);
        cells_to_send.push_back(alive);
        cells_queued++;
    endtask

    // Random cells at a density of alive_in_16 out of 16.
    task automatic queue_random_cells(int count, int alive_in_16);
        for (int i = 0; i < count; i++)
            queue_cell($urandom_range(0, 15) < alive_in_16);
    endtask

    task automatic new_grid(int rows, int cols);
        write_reg(ADDR_GRID_ROWS, APB_DW'(rows));
        write_reg(ADDR_GRID_COLS, APB_DW'(cols));
    endtask

    initial
    begin
        int rows;
        int cols;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        cells_queued   = 0;
        grid_rows_reg  = ROW_W'(64);
        grid_cols_reg  = COL_W'(32);
        clear_rows();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: a few cells at reset size, abandoned by the next register write.
        queue_cell(1'b1);
        queue_cell(1'b1);
        queue_cell(1'b0);
        queue_cell(1'b1);
        wait_drained();

        // Zero rows and zero columns both act as one: a 1x1 grid, every cell
        // is a whole generation.
        new_grid(0, 0);
        queue_cell(1'b1);
        queue_cell(1'b0);
        queue_cell(1'b1);
        wait_drained();

        // Single-row grid: nothing until the row ends, then the flush.
        new_grid(1, 5);
        queue_cell(1'b0);
        queue_cell(1'b1);
        queue_cell(1'b1);
        queue_cell(1'b1);
        queue_cell(1'b0);
        wait_drained();

        // Vertical blinker on 3x3: births and deaths both show up.
        new_grid(3, 3);
        for (int i = 0; i < 9; i++)
            queue_cell(i % 3 == 1);
        wait_drained();

        // Column count above the limit acts as the limit; junk in the upper
        // write data bits is dropped.
        write_reg(ADDR_GRID_ROWS, {20'($urandom_range(0, 1048575)), 12'd2});
        write_reg(ADDR_GRID_COLS, APB_DW'(63));
        queue_random_cells(2 * MAX_COLS, $urandom_range(4, 12));
        wait_drained();

        // Widest single row: the longest flush.
        new_grid(1, MAX_COLS);
        queue_random_cells(MAX_COLS, 8);
        wait_drained();

        // Tallest grid, left unfinished.
        new_grid(4095, 3);
        queue_random_cells(45, $urandom_range(3, 13));
        wait_drained();

        new_grid(5, 7);
        for (int g = 0; g < 3; g++)
            queue_random_cells(35, $urandom_range(3, 12));
        wait_drained();

        // Random grid sizes, one or two full generations each.
        while (cells_queued < 480)
        begin
            rows = $urandom_range(2, 6);
            cols = $urandom_range(1, 12);
            new_grid(rows, cols);
            repeat ($urandom_range(1, 2))
                queue_random_cells(rows * cols, $urandom_range(3, 12));
            wait_drained();
        end

        repeat (30) @(negedge clk);
        if (mismatch_count == 0 && expected_cells.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lgs_pkg.sv
rtl/lgs_front.sv
rtl/lgs_queue.sv
rtl/lgs_back.sv
rtl/life_generation_stream.sv
bench/tb.sv
